>>> hdl/owtr_pkg.sv
// owtr_pkg: shared types, codes and constants of the one-wire temperature reader
// no dependencies; imported by owtr_step, onewire_temperature_reader and the testbench
package owtr_pkg;

  // input kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CHECK = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_RESET_RECOVER = 3'd1;
  localparam logic [2:0] REG_PRES_FALL     = 3'd2;
  localparam logic [2:0] REG_PRES_RISE     = 3'd3;
  localparam logic [2:0] REG_SLOT          = 3'd4;
  localparam logic [2:0] REG_PULSE         = 3'd5;
  localparam logic [2:0] REG_CONVERT_WAIT  = 3'd6;

  // configuration reset values
  localparam logic [11:0] RESET_LOW_DEF     = 12'd600;
  localparam logic [9:0]  RESET_RECOVER_DEF = 10'd40;
  localparam logic [9:0]  PRES_FALL_DEF     = 10'd200;
  localparam logic [9:0]  PRES_RISE_DEF     = 10'd240;
  localparam logic [7:0]  SLOT_DEF          = 8'd60;
  localparam logic [3:0]  PULSE_DEF         = 4'd2;
  localparam logic [19:0] CONVERT_WAIT_DEF  = 20'd600000;

  // steps of the read sequence
  localparam logic [2:0] STEP_SKIP_ROM_A = 3'd0;
  localparam logic [2:0] STEP_CONVERT    = 3'd1;
  localparam logic [2:0] STEP_SECOND_RST = 3'd2;
  localparam logic [2:0] STEP_SKIP_ROM_B = 3'd3;
  localparam logic [2:0] STEP_READ_CMD   = 3'd4;
  localparam logic [2:0] STEP_READ_LOW   = 3'd5;
  localparam logic [2:0] STEP_READ_HIGH  = 3'd6;
  localparam logic [2:0] STEP_CHECK_ONLY = 3'd7;

  // bus commands
  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_SP  = 8'hBE;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REC   = 4'd2,
    PH_PRES_FALL = 4'd3,
    PH_PRES_RISE = 4'd4,
    PH_W_PULSE   = 4'd5,
    PH_W_DATA    = 4'd6,
    PH_W_REC     = 4'd7,
    PH_R_PULSE   = 4'd8,
    PH_R_REL     = 4'd9,
    PH_R_WAIT    = 4'd10,
    PH_CONV      = 4'd11
  } owtr_phase_t;

  typedef struct packed {
    logic [11:0] reset_low;
    logic [9:0]  reset_recover;
    logic [9:0]  pres_fall_limit;
    logic [9:0]  pres_rise_limit;
    logic [7:0]  slot;
    logic [3:0]  pulse;
    logic [19:0] convert_wait;
  } owtr_cfg_t;

  typedef struct packed {
    owtr_phase_t phase;
    logic [19:0] timer;
    logic [2:0]  bit_idx;
    logic [2:0]  byte_step;
    logic [7:0]  shift_byte;
    logic [7:0]  low_hold;
    logic [15:0] result;
    logic        presence_failed;
  } owtr_state_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy;
    logic        done;
    logic        presence_failed;
    logic [15:0] temperature_raw;
  } owtr_result_t;

  // command byte sent in each write step
  function automatic logic [7:0] step_cmd(input logic [2:0] step);
    logic [7:0] cmd;
    case (step)
      STEP_SKIP_ROM_A: cmd = CMD_SKIP_ROM;
      STEP_CONVERT:    cmd = CMD_CONVERT;
      STEP_SKIP_ROM_B: cmd = CMD_SKIP_ROM;
      STEP_READ_CMD:   cmd = CMD_READ_SP;
      default:         cmd = 8'h00;
    endcase
    return cmd;
  endfunction

endpackage

>>> hdl/onewire_temperature_reader.sv
// onewire_temperature_reader: top level of the one-wire bus master
// depends on owtr_pkg and owtr_step
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    kind, line_level
//   out_     output     out_valid/out_stall  drive_low, busy_res, done_res,
//                                            presence_failed, temperature_raw
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// the bus state advances in the cycle a transaction is accepted, and its result
// sits in the output register on the next edge.
// a new transaction is taken each cycle; the input stalls only while a result
// waits and out_stall is high. configuration is always ready.
// synchronous active-low reset clears the bus state and loads register defaults.
module onewire_temperature_reader (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic        in_line_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_drive_low,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_presence_failed,
  output logic [15:0] out_temperature_raw,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import owtr_pkg::*;

  owtr_cfg_t    cfg_r;
  owtr_state_t  state_r;
  owtr_state_t  state_nxt;
  owtr_result_t res_nxt;
  owtr_result_t res_r;
  logic         out_valid_r;
  logic         in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low       <= RESET_LOW_DEF;
      cfg_r.reset_recover   <= RESET_RECOVER_DEF;
      cfg_r.pres_fall_limit <= PRES_FALL_DEF;
      cfg_r.pres_rise_limit <= PRES_RISE_DEF;
      cfg_r.slot            <= SLOT_DEF;
      cfg_r.pulse           <= PULSE_DEF;
      cfg_r.convert_wait    <= CONVERT_WAIT_DEF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RESET_LOW:     cfg_r.reset_low       <= cfg_data[11:0];
        REG_RESET_RECOVER: cfg_r.reset_recover   <= cfg_data[9:0];
        REG_PRES_FALL:     cfg_r.pres_fall_limit <= cfg_data[9:0];
        REG_PRES_RISE:     cfg_r.pres_rise_limit <= cfg_data[9:0];
        REG_SLOT:          cfg_r.slot            <= cfg_data[7:0];
        REG_PULSE:         cfg_r.pulse           <= cfg_data[3:0];
        REG_CONVERT_WAIT:  cfg_r.convert_wait    <= cfg_data;
        default:           ;
      endcase
    end
  end

  // next state for the incoming transaction
  owtr_step u_step (
    .cur        (state_r),
    .cfg        (cfg_r),
    .kind       (in_kind),
    .line_level (in_line_level),
    .nxt        (state_nxt),
    .res        (res_nxt)
  );

  // bus state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else if (in_accept) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
      res_r       <= res_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_drive_low       = res_r.drive_low;
  assign out_busy_res        = res_r.busy;
  assign out_done_res        = res_r.done;
  assign out_presence_failed = res_r.presence_failed;
  assign out_temperature_raw = res_r.temperature_raw;

endmodule

>>> hdl/owtr_step.sv
// owtr_step: next state and result of the bus master for one transaction
// depends on owtr_pkg
module owtr_step (
  input  owtr_pkg::owtr_state_t  cur,
  input  owtr_pkg::owtr_cfg_t    cfg,
  input  logic [1:0]             kind,
  input  logic                   line_level,
  output owtr_pkg::owtr_state_t  nxt,
  output owtr_pkg::owtr_result_t res
);
  import owtr_pkg::*;

  logic [19:0] lim;
  logic [20:0] timer_inc;
  logic        hit;
  logic        done;
  logic [7:0]  shift_new;
  logic [7:0]  cmd;

  // start of a step of the read sequence
  function automatic owtr_state_t begin_step(input owtr_state_t s);
    owtr_state_t r;
    r = s;
    r.timer = '0;
    r.bit_idx = '0;
    case (s.byte_step)
      STEP_SECOND_RST: r.phase = PH_RST_LOW;
      STEP_READ_LOW, STEP_READ_HIGH: begin
        r.shift_byte = '0;
        r.phase = PH_R_PULSE;
      end
      default: r.phase = PH_W_PULSE;
    endcase
    return r;
  endfunction

  // period limit of the current phase
  always_comb begin
    case (cur.phase)
      PH_RST_LOW:                       lim = {8'd0, cfg.reset_low};
      PH_RST_REC:                       lim = {10'd0, cfg.reset_recover};
      PH_PRES_FALL:                     lim = {10'd0, cfg.pres_fall_limit};
      PH_PRES_RISE:                     lim = {10'd0, cfg.pres_rise_limit};
      PH_W_DATA, PH_R_WAIT:             lim = {12'd0, cfg.slot};
      PH_W_PULSE, PH_R_PULSE, PH_R_REL: lim = {16'd0, cfg.pulse};
      PH_CONV:                          lim = cfg.convert_wait;
      default:                          lim = 20'd1;
    endcase
  end

  // tick counter; a zero limit ends the period at the first tick
  assign timer_inc = {1'b0, cur.timer} + 21'd1;
  assign hit       = timer_inc >= {1'b0, lim};

  // sample shifts in at the first tick of a read wait
  assign shift_new = (cur.timer == 20'd0) ? {line_level, cur.shift_byte[7:1]} : cur.shift_byte;

  // phase sequencing
  always_comb begin
    nxt  = cur;
    done = 1'b0;
    if (kind == KIND_TICK) begin
      if (cur.phase != PH_IDLE) begin
        nxt.timer = hit ? 20'd0 : timer_inc[19:0];
        case (cur.phase)
          PH_RST_LOW: begin
            if (hit) nxt.phase = PH_RST_REC;
          end
          PH_RST_REC: begin
            if (hit) nxt.phase = (cur.byte_step == STEP_SECOND_RST) ? PH_CONV : PH_PRES_FALL;
          end
          PH_PRES_FALL, PH_PRES_RISE: begin
            if (cur.phase == PH_PRES_FALL && !line_level) begin
              nxt.timer = '0;
              nxt.phase = PH_PRES_RISE;
            end else if ((cur.phase == PH_PRES_RISE && line_level) || hit) begin
              // presence check over
              nxt.presence_failed = !(cur.phase == PH_PRES_RISE && line_level);
              if (cur.byte_step == STEP_CHECK_ONLY) begin
                nxt.phase = PH_IDLE;
                nxt.timer = '0;
                done = 1'b1;
              end else begin
                nxt.byte_step = STEP_SKIP_ROM_A;
                nxt = begin_step(nxt);
              end
            end
          end
          PH_CONV: begin
            if (hit) begin
              nxt.byte_step = STEP_SKIP_ROM_B;
              nxt = begin_step(nxt);
            end
          end
          PH_W_PULSE: begin
            if (hit) nxt.phase = PH_W_DATA;
          end
          PH_W_DATA: begin
            if (hit) nxt.phase = PH_W_REC;
          end
          PH_W_REC: begin
            nxt.timer = cur.timer;
            if (cur.bit_idx == 3'd7) begin
              nxt.byte_step = cur.byte_step + 3'd1;
              nxt = begin_step(nxt);
            end else begin
              nxt.bit_idx = cur.bit_idx + 3'd1;
              nxt.timer = '0;
              nxt.phase = PH_W_PULSE;
            end
          end
          PH_R_PULSE: begin
            if (hit) nxt.phase = PH_R_REL;
          end
          PH_R_REL: begin
            if (hit) nxt.phase = PH_R_WAIT;
          end
          PH_R_WAIT: begin
            nxt.shift_byte = shift_new;
            if (hit) begin
              if (cur.bit_idx != 3'd7) begin
                nxt.bit_idx = cur.bit_idx + 3'd1;
                nxt.phase = PH_R_PULSE;
              end else if (cur.byte_step == STEP_READ_LOW) begin
                nxt.low_hold = shift_new;
                nxt.byte_step = STEP_READ_HIGH;
                nxt = begin_step(nxt);
              end else begin
                nxt.result = {shift_new, cur.low_hold};
                nxt.phase = PH_IDLE;
                nxt.timer = '0;
                done = 1'b1;
              end
            end
          end
          default: begin
            nxt.timer = cur.timer;
            nxt.phase = PH_IDLE;
          end
        endcase
      end
    end else if ((kind == KIND_READ || kind == KIND_CHECK) && cur.phase == PH_IDLE) begin
      nxt.byte_step = (kind == KIND_CHECK) ? STEP_CHECK_ONLY : STEP_SKIP_ROM_A;
      nxt.timer = '0;
      nxt.bit_idx = '0;
      nxt.shift_byte = '0;
      nxt.phase = PH_RST_LOW;
    end
  end

  // line drive follows the new phase
  assign cmd = step_cmd(nxt.byte_step);

  always_comb begin
    case (nxt.phase)
      PH_RST_LOW, PH_W_PULSE, PH_R_PULSE: res.drive_low = 1'b1;
      PH_W_DATA:                          res.drive_low = !cmd[nxt.bit_idx];
      default:                            res.drive_low = 1'b0;
    endcase
  end

  assign res.busy            = nxt.phase != PH_IDLE;
  assign res.done            = done;
  assign res.presence_failed = nxt.presence_failed;
  assign res.temperature_raw = nxt.result;

endmodule

>>> test/tb_onewire_temperature_reader.sv
// tb_onewire_temperature_reader: self-checking testbench of the one-wire temperature reader
// depends on owtr_pkg and onewire_temperature_reader; predicts every result
// from a bus model of its own and compares all of its fields
module tb_onewire_temperature_reader;
  timeunit 1ns;
  timeprecision 1ps;

  import owtr_pkg::*;

  // codes with no name in the package
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] REG_UNUSED  = 3'd7;

  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DEV_NEVER    = 4096;
  localparam int RANDOM_ITEMS = 300;
  localparam int CALM_ITEMS   = 220;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = KIND_TICK;
  logic        in_line_level = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_drive_low;
  logic        out_busy_res;
  logic        out_done_res;
  logic        out_presence_failed;
  logic [15:0] out_temperature_raw;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_RESET_LOW;
  logic [19:0] cfg_data = '0;

  onewire_temperature_reader dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_line_level       (in_line_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_drive_low       (out_drive_low),
    .out_busy_res        (out_busy_res),
    .out_done_res        (out_done_res),
    .out_presence_failed (out_presence_failed),
    .out_temperature_raw (out_temperature_raw),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #1 clk = ~clk;

  // shared control between stimulus, receiver and checker
  bit           idle_on = 1'b1;
  bit           hold_req = 1'b0;
  int           mismatches = 0;
  int           result_count = 0;
  int           work_items = 0;
  int           quiet_cycles = 0;
  owtr_result_t bus_result_q[$];

  // bus master model: register copy and sequence state
  owtr_cfg_t   reg_sh;
  owtr_phase_t ph;
  logic [19:0] tmr;
  logic [2:0]  bit_i;
  logic [2:0]  step;
  logic [7:0]  shreg;
  logic [7:0]  low_hold;
  logic [15:0] raw_val;
  logic        pres_fail;
  logic        seq_done;

  // simulated sensor on the line
  int          dev_fall;
  int          dev_rise;
  logic [15:0] dev_word;

  function automatic void model_reset();
    reg_sh.reset_low       = RESET_LOW_DEF;
    reg_sh.reset_recover   = RESET_RECOVER_DEF;
    reg_sh.pres_fall_limit = PRES_FALL_DEF;
    reg_sh.pres_rise_limit = PRES_RISE_DEF;
    reg_sh.slot            = SLOT_DEF;
    reg_sh.pulse           = PULSE_DEF;
    reg_sh.convert_wait    = CONVERT_WAIT_DEF;
    ph = PH_IDLE;
    tmr = '0;
    bit_i = '0;
    step = '0;
    shreg = '0;
    low_hold = '0;
    raw_val = '0;
    pres_fail = 1'b0;
    seq_done = 1'b0;
  endfunction

  function automatic void apply_config(input logic [2:0] idx, input logic [19:0] d);
    case (idx)
      REG_RESET_LOW:     reg_sh.reset_low = d[11:0];
      REG_RESET_RECOVER: reg_sh.reset_recover = d[9:0];
      REG_PRES_FALL:     reg_sh.pres_fall_limit = d[9:0];
      REG_PRES_RISE:     reg_sh.pres_rise_limit = d[9:0];
      REG_SLOT:          reg_sh.slot = d[7:0];
      REG_PULSE:         reg_sh.pulse = d[3:0];
      REG_CONVERT_WAIT:  reg_sh.convert_wait = d;
      default: ;
    endcase
  endfunction

  // one more tick of a period; a zero length behaves as one tick
  function automatic bit timer_expired(input logic [19:0] lim);
    tmr = tmr + 20'd1;
    if (tmr >= lim) begin
      tmr = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void begin_step();
    tmr = '0;
    bit_i = '0;
    if (step == STEP_SECOND_RST) begin
      ph = PH_RST_LOW;
    end else if (step == STEP_READ_LOW || step == STEP_READ_HIGH) begin
      shreg = '0;
      ph = PH_R_PULSE;
    end else begin
      ph = PH_W_PULSE;
    end
  endfunction

  function automatic void finish_sequence();
    ph = PH_IDLE;
    tmr = '0;
    seq_done = 1'b1;
  endfunction

  // a failed check is recorded but a read goes on
  function automatic void end_presence(input logic failed);
    pres_fail = failed;
    if (step == STEP_CHECK_ONLY) begin
      finish_sequence();
    end else begin
      step = STEP_SKIP_ROM_A;
      begin_step();
    end
  endfunction

  function automatic void advance_tick(input logic line);
    case (ph)
      PH_RST_LOW: if (timer_expired(reg_sh.reset_low)) ph = PH_RST_REC;
      PH_RST_REC: begin
        if (timer_expired(reg_sh.reset_recover)) begin
          if (step == STEP_SECOND_RST) ph = PH_CONV;
          else ph = PH_PRES_FALL;
        end
      end
      PH_PRES_FALL: begin
        if (!line) begin
          tmr = '0;
          ph = PH_PRES_RISE;
        end else if (timer_expired(reg_sh.pres_fall_limit)) begin
          end_presence(1'b1);
        end
      end
      PH_PRES_RISE: begin
        if (line) end_presence(1'b0);
        else if (timer_expired(reg_sh.pres_rise_limit)) end_presence(1'b1);
      end
      PH_CONV: begin
        if (timer_expired(reg_sh.convert_wait)) begin
          step = STEP_SKIP_ROM_B;
          begin_step();
        end
      end
      PH_W_PULSE: if (timer_expired(reg_sh.pulse)) ph = PH_W_DATA;
      PH_W_DATA: if (timer_expired(reg_sh.slot)) ph = PH_W_REC;
      PH_W_REC: begin
        if (bit_i >= 3'd7) begin
          step = step + 3'd1;
          begin_step();
        end else begin
          bit_i = bit_i + 3'd1;
          tmr = '0;
          ph = PH_W_PULSE;
        end
      end
      PH_R_PULSE: if (timer_expired(reg_sh.pulse)) ph = PH_R_REL;
      PH_R_REL: if (timer_expired(reg_sh.pulse)) ph = PH_R_WAIT;
      PH_R_WAIT: begin
        // sample on the first tick of the slot, bytes arrive lsb first
        if (tmr == '0) shreg = {line, shreg[7:1]};
        if (timer_expired(reg_sh.slot)) begin
          if (bit_i < 3'd7) begin
            bit_i = bit_i + 3'd1;
            ph = PH_R_PULSE;
          end else if (step == STEP_READ_LOW) begin
            low_hold = shreg;
            step = STEP_READ_HIGH;
            begin_step();
          end else begin
            raw_val = {shreg, low_hold};
            finish_sequence();
          end
        end
      end
      default: ph = PH_IDLE;
    endcase
  endfunction

  // expected result of one accepted transaction
  function automatic owtr_result_t predict_bus_result(input logic [1:0] k, input logic lv);
    owtr_result_t res;
    logic [7:0]   cmd;
    seq_done = 1'b0;
    if (k == KIND_TICK) begin
      if (ph != PH_IDLE) begin
        work_items++;
        advance_tick(lv);
      end
    end else if ((k == KIND_READ || k == KIND_CHECK) && ph == PH_IDLE) begin
      work_items++;
      step = (k == KIND_CHECK) ? STEP_CHECK_ONLY : STEP_SKIP_ROM_A;
      tmr = '0;
      bit_i = '0;
      shreg = '0;
      ph = PH_RST_LOW;
    end
    case (step)
      STEP_SKIP_ROM_A, STEP_SKIP_ROM_B: cmd = CMD_SKIP_ROM;
      STEP_CONVERT:                     cmd = CMD_CONVERT;
      STEP_READ_CMD:                    cmd = CMD_READ_SP;
      default:                          cmd = 8'h00;
    endcase
    case (ph)
      PH_RST_LOW, PH_W_PULSE, PH_R_PULSE: res.drive_low = 1'b1;
      PH_W_DATA:                          res.drive_low = ~cmd[bit_i];
      default:                            res.drive_low = 1'b0;
    endcase
    res.busy = (ph != PH_IDLE);
    res.done = seq_done;
    res.presence_failed = pres_fail;
    res.temperature_raw = raw_val;
    return res;
  endfunction

  // line level the sensor shows for the next tick
  function automatic logic sensor_line(input bit noisy);
    logic rnd;
    rnd = 1'($urandom_range(0, 1));
    if (noisy) return rnd;
    case (ph)
      PH_PRES_FALL: return (tmr < dev_fall) ? 1'b1 : 1'b0;
      PH_PRES_RISE: return (tmr < dev_rise) ? 1'b0 : 1'b1;
      PH_R_WAIT:    return (tmr == '0) ? dev_word[{step == STEP_READ_HIGH, bit_i}] : rnd;
      default:      return rnd;
    endcase
  endfunction

  // input transaction: optional gap, then hold until accepted
  task automatic send_item(input logic [1:0] k, input logic lv);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_line_level <= lv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bus_result_q.push_back(predict_bus_result(k, lv));
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [19:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_config(idx, d);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [19:0] rl, input logic [19:0] rr,
                            input logic [19:0] pf, input logic [19:0] pr,
                            input logic [19:0] sl, input logic [19:0] pu,
                            input logic [19:0] cw);
    cfg_write(REG_RESET_LOW, rl);
    cfg_write(REG_RESET_RECOVER, rr);
    cfg_write(REG_PRES_FALL, pf);
    cfg_write(REG_PRES_RISE, pr);
    cfg_write(REG_SLOT, sl);
    cfg_write(REG_PULSE, pu);
    cfg_write(REG_CONVERT_WAIT, cw);
  endtask

  // wait until every result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (bus_result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_device(input int fall, input int rise, input logic [15:0] word);
    dev_fall = fall;
    dev_rise = rise;
    dev_word = word;
  endtask

  // one command, then ticks, with an occasional injected item when asked, until the sequence is over
  task automatic run_sequence(input logic [1:0] cmd, input bit noisy, input bit inject);
    send_item(cmd, 1'($urandom_range(0, 1)));
    while (ph != PH_IDLE) begin
      if (inject && $urandom_range(0, 29) == 0)
        send_item(2'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
      else
        send_item(KIND_TICK, sensor_line(noisy));
    end
  endtask

  // small random value, sometimes zero, with junk above the register width
  function automatic logic [19:0] rand_reg(input int hi, input int w);
    logic [19:0] v;
    v = ($urandom_range(0, 7) == 0) ? 20'd0 : 20'($urandom_range(1, hi));
    if (w < 20) v = v | 20'($urandom << w);
    return v;
  endfunction

  task automatic random_config();
    set_config(rand_reg(6, 12), rand_reg(4, 10), rand_reg(6, 10), rand_reg(6, 10),
               rand_reg(3, 8), rand_reg(2, 4), rand_reg(8, 20));
    if ($urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, 20'($urandom));
  endtask

  // defaults after reset: one presence check
  task automatic test_default_timing();
    set_device(3, 2, 16'h0000);
    run_sequence(KIND_CHECK, 1'b0, 1'b0);
  endtask

  // items that leave an idle block alone
  task automatic test_idle_items();
    send_item(KIND_TICK, 1'b0);
    send_item(KIND_TICK, 1'b1);
    send_item(KIND_UNUSED, 1'b0);
    send_item(KIND_UNUSED, 1'b1);
  endtask

  // presence found, no device, line stuck low, fall limit edge
  task automatic test_presence();
    drain();
    set_config(20'd3, 20'd2, 20'd4, 20'd4, 20'd1, 20'd1, 20'd1);
    set_device(1, 1, 16'h0000);
    run_sequence(KIND_CHECK, 1'b0, 1'b0);
    set_device(DEV_NEVER, 0, 16'h0000);
    run_sequence(KIND_CHECK, 1'b0, 1'b0);
    set_device(0, DEV_NEVER, 16'h0000);
    run_sequence(KIND_CHECK, 1'b0, 1'b0);
    set_device(3, 3, 16'h0000);
    run_sequence(KIND_CHECK, 1'b0, 1'b0);
    set_device(4, 0, 16'h0000);
    run_sequence(KIND_CHECK, 1'b0, 1'b0);
  endtask

  // reads of edge values, commands while busy, read without a device
  task automatic test_read_values();
    set_device(0, 0, 16'hFFFF);
    run_sequence(KIND_READ, 1'b0, 1'b1);
    set_device(2, 1, 16'h8001);
    run_sequence(KIND_READ, 1'b0, 1'b1);
    set_device(DEV_NEVER, 0, 16'hA55A);
    run_sequence(KIND_READ, 1'b0, 1'b0);
  endtask

  // all registers zero behave as one
  task automatic test_zero_registers();
    drain();
    set_config(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
    set_device(0, 0, 16'h5AA5);
    run_sequence(KIND_READ, 1'b0, 1'b0);
    set_device(DEV_NEVER, 0, 16'h0000);
    run_sequence(KIND_CHECK, 1'b0, 1'b0);
  endtask

  // widest presence, slot, pulse and convert values, with a device that answers early
  task automatic test_register_extremes();
    drain();
    set_config(20'd1, 20'd1, 20'd1023, 20'd1023, 20'd255, 20'd15, 20'hFFFFF);
    set_device(6, 9, 16'h0000);
    run_sequence(KIND_CHECK, 1'b0, 1'b0);
    set_device(0, 3, 16'h0000);
    run_sequence(KIND_CHECK, 1'b0, 1'b0);
  endtask

  // receiver holds off while a read keeps offering ticks
  task automatic test_backpressure();
    drain();
    set_config(20'd2, 20'd2, 20'd5, 20'd5, 20'd3, 20'd1, 20'd4);
    set_device(1, 2, 16'h1234);
    hold_req = 1'b1;
    run_sequence(KIND_READ, 1'b0, 1'b0);
  endtask

  // random sequences with random registers, mostly well formed
  task automatic test_random();
    int base;
    int pick;
    base = work_items;
    while (work_items - base < RANDOM_ITEMS) begin
      if (work_items - base >= CALM_ITEMS) idle_on = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
        drain();
        random_config();
      end
      set_device($urandom_range(0, int'(reg_sh.pres_fall_limit) + 2),
                 $urandom_range(0, int'(reg_sh.pres_rise_limit) + 2), 16'($urandom));
      if ($urandom_range(0, 3) == 0) send_item(KIND_TICK, 1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 19);
      if (pick < 10)
        run_sequence(KIND_READ, $urandom_range(0, 4) == 0, 1'b1);
      else if (pick < 17)
        run_sequence(KIND_CHECK, $urandom_range(0, 4) == 0, 1'b1);
      else
        send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
  endtask

  // receiver stall bursts and the long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && rst_n && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    owtr_result_t got_res;
    owtr_result_t want_res;
    if (rst_n && out_valid && !out_stall) begin
      got_res.drive_low = out_drive_low;
      got_res.busy = out_busy_res;
      got_res.done = out_done_res;
      got_res.presence_failed = out_presence_failed;
      got_res.temperature_raw = out_temperature_raw;
      if (bus_result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d with nothing expected: drive_low %b busy %b done %b pf %b raw %h",
                   result_count, got_res.drive_low, got_res.busy, got_res.done,
                   got_res.presence_failed, got_res.temperature_raw);
      end else begin
        want_res = bus_result_q.pop_front();
        if (got_res !== want_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d: expected drive_low %b busy %b done %b pf %b raw %h,",
                      " got drive_low %b busy %b done %b pf %b raw %h"},
                     result_count, want_res.drive_low, want_res.busy, want_res.done,
                     want_res.presence_failed, want_res.temperature_raw,
                     got_res.drive_low, got_res.busy, got_res.done,
                     got_res.presence_failed, got_res.temperature_raw);
        end
      end
      result_count++;
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // test sequence
  initial begin
    model_reset();
    set_device(0, 0, 16'h0000);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_timing();
    test_idle_items();
    test_presence();
    test_read_values();
    test_zero_registers();
    test_register_extremes();
    test_backpressure();
    test_random();
    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/owtr_pkg.sv
hdl/owtr_step.sv
hdl/onewire_temperature_reader.sv
test/tb_onewire_temperature_reader.sv
